// File: src/bra_pkg.sv
// bra_pkg: shared constants, op and status codes, word scan result type
// for the bitmap run allocator. no dependencies.
`default_nettype none
package bra_pkg;

  localparam int MAP_WORDS = 32;
  localparam int WORD_BITS = 32;
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int POS_W     = 10;
  localparam int ADDR_W    = POS_W - OFF_W;
  localparam int CNT_W     = 11;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;
  localparam int CFG_W     = 6;
  localparam int LEAD_W    = OFF_W + 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_BIT   = 3'd1;
  localparam logic [OP_W-1:0] OP_CLR_BIT   = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_RANGE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLR_RANGE = 3'd4;
  localparam logic [OP_W-1:0] OP_SET_ALL   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLR_ALL   = 3'd6;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
  localparam logic [ST_W-1:0] ST_NORUN  = 2'd2;

  // outcome of scanning one map word
  typedef struct packed {
    logic              found;
    logic              at_run_start;
    logic [OFF_W-1:0]  hit_off;
    logic              all_clear;
    logic [LEAD_W-1:0] trail;
  } scan_res_t;

endpackage
`default_nettype wire

// File: src/bitmap_run_allocator_top.sv
// bitmap_run_allocator_top: bitmap map memory, operation sequencer and run search.
// depends on bra_pkg and bra_word_scan.
// search: one map word per cycle from the start word, strobed on a found run or
//   at the last word in use (at most 32 words); ranges: a masked rewrite of each
//   word touched; set/clear all: fill words in use; rejects strobe next cycle.
// the word scan unit and the single map read port set the one-word-per-cycle pace.
// reset: map reads all clear through per-word valid flags, no clearing pass;
//   words_in_use returns to 32. results are strobed and cannot be stalled.
`default_nettype none
module bitmap_run_allocator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [bra_pkg::OP_W-1:0]   op,
  input  logic [bra_pkg::POS_W-1:0]  start_bit,
  input  logic [bra_pkg::CNT_W-1:0]  bit_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bra_pkg::CFG_W-1:0]  cfg_data,
  output logic                       result_valid,
  output logic [bra_pkg::ST_W-1:0]   status,
  output logic [bra_pkg::POS_W-1:0]  position
);
  import bra_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RMW, S_FILL} state_t;

  state_t                state;
  logic [CFG_W-1:0]      words_in_use;
  logic [CFG_W-1:0]      used;
  logic [CNT_W-1:0]      size;
  logic [ADDR_W-1:0]     last_word;
  logic [CNT_W:0]        end_sum;
  logic [POS_W-1:0]      end_pos;
  logic                  search_bad;
  logic                  range_bad;

  logic [OP_W-1:0]       op_q;
  logic [POS_W-1:0]      start_q;
  logic [POS_W-1:0]      end_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  set_q;
  logic                  first;
  logic [ADDR_W-1:0]     word_idx;
  logic [CNT_W-1:0]      carry;
  logic [POS_W-1:0]      run_start;
  logic [CNT_W-1:0]      carry_next;
  logic [CNT_W-1:0]      run_start_next;

  logic [WORD_BITS-1:0]  mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]  word_valid;
  logic [WORD_BITS-1:0]  rd_q;
  logic                  rd_vld;
  logic [ADDR_W-1:0]     rd_addr;
  logic [WORD_BITS-1:0]  word;
  logic                  mem_we;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic [WORD_BITS-1:0]  mask;
  logic [OFF_W-1:0]      lo_off;
  logic [OFF_W-1:0]      hi_off;

  scan_res_t             res;

  // configuration register
  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= CFG_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      words_in_use <= cfg_data;
    end
  end

  // map geometry from the word count
  assign used      = (words_in_use > CFG_W'(MAP_WORDS)) ? CFG_W'(MAP_WORDS) : words_in_use;
  assign size      = {used, {OFF_W{1'b0}}};
  assign last_word = ADDR_W'(used - CFG_W'(1));

  // request checks at accept
  assign end_sum    = {1'b0, CNT_W'(start_bit)} + {1'b0, bit_count};
  assign end_pos    = POS_W'(end_sum - (CNT_W+1)'(1));
  assign range_bad  = end_sum >= {1'b0, size};
  assign search_bad = (bit_count == '0) || (bit_count >= size) ||
                      (CNT_W'(start_bit) >= size);

  // map memory, one read and one write port, read data registered
  assign rd_addr = (state == S_IDLE) ? start_bit[POS_W-1:OFF_W] : word_idx + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) mem[word_idx] <= mem_wdata;
    rd_q   <= mem[rd_addr];
    rd_vld <= word_valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (mem_we) begin
      word_valid[word_idx] <= 1'b1;
    end
  end

  assign word = rd_vld ? rd_q : '0;

  // range mask for the current word
  assign lo_off = (word_idx == start_q[POS_W-1:OFF_W]) ? start_q[OFF_W-1:0] : '0;
  assign hi_off = (word_idx == end_q[POS_W-1:OFF_W]) ? end_q[OFF_W-1:0] : '1;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[WORD_BITS-1-j] = (OFF_W'(j) >= lo_off) && (OFF_W'(j) <= hi_off);
    end
  end

  // write side: masked read-modify-write or whole-word fill
  assign mem_we = (state == S_RMW) || (state == S_FILL);

  always_comb begin
    if (state == S_FILL) begin
      mem_wdata = {WORD_BITS{set_q}};
    end else if (set_q) begin
      mem_wdata = word | mask;
    end else begin
      mem_wdata = word & ~mask;
    end
  end

  // word scan unit for the run search
  bra_word_scan u_scan (
    .word   (word),
    .first  (first),
    .offset (start_q[OFF_W-1:0]),
    .carry  (carry),
    .cnt    (cnt_q),
    .res    (res)
  );

  // run carry and run start into the next word
  assign carry_next     = res.all_clear ? carry + CNT_W'(WORD_BITS) : CNT_W'(res.trail);
  assign run_start_next = {1'b0, word_idx, {OFF_W{1'b0}}} + CNT_W'(WORD_BITS)
                          - CNT_W'(res.trail);

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q      <= op;
            start_q   <= start_bit;
            end_q     <= ((op == OP_SET_BIT) || (op == OP_CLR_BIT)) ? start_bit : end_pos;
            cnt_q     <= bit_count;
            set_q     <= (op == OP_SET_BIT) || (op == OP_SET_RANGE) || (op == OP_SET_ALL);
            first     <= 1'b1;
            word_idx  <= ((op == OP_SET_ALL) || (op == OP_CLR_ALL)) ? '0
                                                                     : start_bit[POS_W-1:OFF_W];
            carry     <= '0;
            run_start <= {start_bit[POS_W-1:OFF_W], {OFF_W{1'b0}}};
            position  <= '0;
            case (op)
              OP_SEARCH: begin
                if (search_bad) begin
                  result_valid <= 1'b1;
                  status       <= ST_NORUN;
                end else begin
                  result_valid <= 1'b0;
                  state        <= S_SCAN;
                  busy         <= 1'b1;
                end
              end
              OP_SET_BIT, OP_CLR_BIT: begin
                if (CNT_W'(start_bit) >= size) begin
                  result_valid <= 1'b1;
                  status       <= ST_REJECT;
                end else begin
                  result_valid <= 1'b0;
                  state        <= S_RMW;
                  busy         <= 1'b1;
                end
              end
              OP_SET_RANGE, OP_CLR_RANGE: begin
                if (range_bad) begin
                  result_valid <= 1'b1;
                  status       <= ST_REJECT;
                end else if (bit_count == '0) begin
                  result_valid <= 1'b1;
                  status       <= ST_DONE;
                end else begin
                  result_valid <= 1'b0;
                  state        <= S_RMW;
                  busy         <= 1'b1;
                end
              end
              OP_SET_ALL, OP_CLR_ALL: begin
                if (used == '0) begin
                  result_valid <= 1'b1;
                  status       <= ST_DONE;
                end else begin
                  result_valid <= 1'b0;
                  state        <= S_FILL;
                  busy         <= 1'b1;
                end
              end
              default: begin
                result_valid <= 1'b1;
                status       <= ST_REJECT;
              end
            endcase
          end else begin
            result_valid <= 1'b0;
          end
        end
        S_SCAN: begin
          first <= 1'b0;
          if (res.found) begin
            result_valid <= 1'b1;
            status       <= ST_DONE;
            position     <= res.at_run_start ? run_start : {word_idx, res.hit_off};
            state        <= S_IDLE;
            busy         <= 1'b0;
          end else if (word_idx == last_word) begin
            result_valid <= 1'b1;
            status       <= ST_NORUN;
            state        <= S_IDLE;
            busy         <= 1'b0;
          end else begin
            result_valid <= 1'b0;
            word_idx     <= word_idx + ADDR_W'(1);
            carry        <= carry_next;
            if (!res.all_clear) run_start <= run_start_next[POS_W-1:0];
          end
        end
        S_RMW: begin
          if (word_idx == end_q[POS_W-1:OFF_W]) begin
            result_valid <= 1'b1;
            status       <= ST_DONE;
            state        <= S_IDLE;
            busy         <= 1'b0;
          end else begin
            result_valid <= 1'b0;
            word_idx     <= word_idx + ADDR_W'(1);
          end
        end
        S_FILL: begin
          if (word_idx == last_word) begin
            result_valid <= 1'b1;
            status       <= ST_DONE;
            state        <= S_IDLE;
            busy         <= 1'b0;
          end else begin
            result_valid <= 1'b0;
            word_idx     <= word_idx + ADDR_W'(1);
          end
        end
        default: begin
          result_valid <= 1'b0;
          state        <= S_IDLE;
          busy         <= 1'b0;
        end
      endcase
    end
  end

  // busy flag tracks the sequencer
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy flag out of step with sequencer");

  // a search never writes the map
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !mem_we)
    else $error("map written during search");

  // the scan stays inside the words in use
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (word_idx <= last_word))
    else $error("scan beyond last word in use");

  // a nonzero position only comes with a found run
  a_pos_found: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (position != '0)) |-> (status == ST_DONE && op_q == OP_SEARCH))
    else $error("position reported without a found run");

  // no run only reported for a search
  a_norun_search: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_NORUN) |-> (op_q == OP_SEARCH))
    else $error("no-run status for a non-search word");

endmodule
`default_nettype wire

// File: src/bra_word_scan.sv
// bra_word_scan: run search over one 32-bit map word with an incoming run carry.
// depends on bra_pkg.
`default_nettype none
module bra_word_scan (
  input  logic [bra_pkg::WORD_BITS-1:0] word,
  input  logic                          first,
  input  logic [bra_pkg::OFF_W-1:0]     offset,
  input  logic [bra_pkg::CNT_W-1:0]     carry,
  input  logic [bra_pkg::CNT_W-1:0]     cnt,
  output bra_pkg::scan_res_t            res
);
  import bra_pkg::*;

  logic [WORD_BITS-1:0]   z;
  logic [2*WORD_BITS-1:0] zz;
  logic [WORD_BITS-1:0]   hit;
  logic [LEAD_W-1:0]      lead;
  logic [OFF_W-1:0]       last_set;
  logic [OFF_W-1:0]       hit_off;
  logic                   all_clear;
  logic                   lead_ok;
  logic                   hit_any;

  // clear flags in position order, positions before the start offset forced busy in the first word
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      z[j] = ~word[WORD_BITS-1-j] & (~first | (OFF_W'(j) >= offset));
    end
    zz = {{WORD_BITS{1'b0}}, z};
  end

  // leading clear count and last busy position
  always_comb begin
    lead     = LEAD_W'(WORD_BITS);
    last_set = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!z[j]) lead = LEAD_W'(j);
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      if (!z[j]) last_set = OFF_W'(j);
    end
  end

  assign all_clear = &z;

  // run of cnt clear positions starting at each position inside the word
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      hit[j] = 1'b1;
      for (int k = 0; k < WORD_BITS; k++) begin
        hit[j] = hit[j] & (zz[j+k] | (CNT_W'(k) >= cnt));
      end
    end
  end

  // lowest hit position
  always_comb begin
    hit_off = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit[j]) hit_off = OFF_W'(j);
    end
  end

  assign hit_any = (cnt < CNT_W'(WORD_BITS)) & (|hit);
  assign lead_ok = ({1'b0, carry} + (CNT_W+1)'(lead)) >= {1'b0, cnt};

  always_comb begin
    res.found        = lead_ok | hit_any;
    res.at_run_start = lead_ok;
    res.hit_off      = hit_off;
    res.all_clear    = all_clear;
    res.trail        = all_clear ? LEAD_W'(WORD_BITS)
                                 : {1'b0, OFF_W'(WORD_BITS - 1) - last_set};
  end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for bitmap_run_allocator_top, with a local bitmap
// predictor, a queued request driver and a result monitor. depends on bra_pkg.
module tb_top;
  import bra_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 3'd7;  // undefined op code
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 68;

  typedef enum logic [1:0] {ACT_REQUEST, ACT_CONFIG, ACT_DRAIN} action_kind_t;

  typedef struct {
    action_kind_t     kind;
    logic [OP_W-1:0]  req_op;
    logic [POS_W-1:0] req_bit;
    logic [CNT_W-1:0] req_len;
    logic [CFG_W-1:0] cfg_val;
    int               idle_pct;
  } action_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
  } outcome_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [OP_W-1:0]  op = '0;
  logic [POS_W-1:0] start_bit = '0;
  logic [CNT_W-1:0] bit_count = '0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             result_valid;
  logic [ST_W-1:0]  status;
  logic [POS_W-1:0] position;

  // predictor state: the map and the words-in-use register
  logic [WORD_BITS-1:0] map_words [MAP_WORDS];
  logic [CFG_W-1:0]     words_cfg = 6'd32;

  action_t  pending [$];
  outcome_t outstanding [$];
  int requests_sent = 0, requests_taken = 0;
  int cfg_sent = 0, cfg_taken = 0;
  int gap_left = 0;
  int fail_count = 0;
  int idle_pct_now = 0;

  bitmap_run_allocator_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .start_bit(start_bit), .bit_count(bit_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .status(status), .position(position)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  function automatic int map_size_bits();
    int words;
    words = (int'(words_cfg) > MAP_WORDS) ? MAP_WORDS : int'(words_cfg);
    return words * WORD_BITS;
  endfunction

  // position p sits in word p/32, msb first
  function automatic logic bit_at(input int p);
    return map_words[p / WORD_BITS][WORD_BITS - 1 - (p % WORD_BITS)];
  endfunction

  function automatic void put_bit(input int p, input logic v);
    map_words[p / WORD_BITS][WORD_BITS - 1 - (p % WORD_BITS)] = v;
  endfunction

  // apply one request to the local map and return its result word
  function automatic outcome_t apply_request(input logic [OP_W-1:0] req_op,
                                             input logic [POS_W-1:0] req_bit,
                                             input logic [CNT_W-1:0] req_len);
    outcome_t res;
    int map_bits, run, p, w;
    logic hit;
    map_bits = map_size_bits();
    res.status = ST_DONE;
    res.position = '0;
    case (req_op)
      OP_SEARCH: begin
        res.status = ST_NORUN;
        if (req_len != 0 && int'(req_len) < map_bits && int'(req_bit) < map_bits) begin
          run = 0;
          hit = 1'b0;
          for (p = int'(req_bit); p < map_bits && !hit; p++) begin
            if (!bit_at(p)) begin
              run++;
              if (run == int'(req_len)) begin
                res.status = ST_DONE;
                res.position = POS_W'(p + 1 - run);
                hit = 1'b1;
              end
            end else begin
              run = 0;
            end
          end
        end
      end
      OP_SET_BIT, OP_CLR_BIT: begin
        if (int'(req_bit) >= map_bits) res.status = ST_REJECT;
        else put_bit(int'(req_bit), req_op == OP_SET_BIT);
      end
      OP_SET_RANGE, OP_CLR_RANGE: begin
        // strict bound: start plus length must stay below the map size
        if (int'(req_bit) + int'(req_len) >= map_bits) begin
          res.status = ST_REJECT;
        end else begin
          for (p = 0; p < int'(req_len); p++)
            put_bit(int'(req_bit) + p, req_op == OP_SET_RANGE);
        end
      end
      OP_SET_ALL, OP_CLR_ALL: begin
        for (w = 0; w < map_bits / WORD_BITS; w++)
          map_words[w] = (req_op == OP_SET_ALL) ? '1 : '0;
      end
      default: res.status = ST_REJECT;
    endcase
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic add_request(input logic [OP_W-1:0] o, input int b, input int n);
    action_t a;
    a.kind = ACT_REQUEST;
    a.req_op = o;
    a.req_bit = POS_W'(b);
    a.req_len = CNT_W'(n);
    a.cfg_val = '0;
    a.idle_pct = idle_pct_now;
    pending.push_back(a);
  endtask

  task automatic add_config(input int v);
    action_t a;
    a.kind = ACT_CONFIG;
    a.req_op = OP_SEARCH;
    a.req_bit = '0;
    a.req_len = '0;
    a.cfg_val = CFG_W'(v);
    a.idle_pct = 0;
    pending.push_back(a);
  endtask

  task automatic add_drain();
    action_t a;
    a.kind = ACT_DRAIN;
    a.req_op = OP_SEARCH;
    a.req_bit = '0;
    a.req_len = '0;
    a.cfg_val = '0;
    a.idle_pct = 0;
    pending.push_back(a);
  endtask

  // random requests shaped to fragment the map and search it
  task automatic add_random(input int count, input int words);
    int map_bits, i, r, b, n;
    logic [OP_W-1:0] o;
    map_bits = ((words > MAP_WORDS) ? MAP_WORDS : words) * WORD_BITS;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 36) o = OP_SEARCH;
      else if (r < 48) o = OP_SET_BIT;
      else if (r < 58) o = OP_CLR_BIT;
      else if (r < 74) o = OP_SET_RANGE;
      else if (r < 92) o = OP_CLR_RANGE;
      else if (r < 95) o = OP_SET_ALL;
      else if (r < 99) o = OP_CLR_ALL;
      else o = OP_NONE;
      if (map_bits > 0 && $urandom_range(0, 9) != 0) b = $urandom_range(0, map_bits - 1);
      else b = $urandom_range(0, 1023);
      r = $urandom_range(0, 99);
      case (o)
        OP_SEARCH: begin
          if (r < 3) n = 0;
          else if (r < 70) n = $urandom_range(1, 12);
          else if (r < 90) n = $urandom_range(13, 96);
          else if (r < 97) n = $urandom_range(1, map_bits + 1);
          else n = $urandom_range(0, 2047);
        end
        OP_SET_RANGE, OP_CLR_RANGE: begin
          if (r < 85) n = $urandom_range(0, 40);
          else if (r < 95) n = $urandom_range(0, map_bits);
          else n = $urandom_range(0, 2047);
          // mostly keep ranges inside the map
          if (b + n >= map_bits && map_bits > n && $urandom_range(0, 4) != 0)
            b = $urandom_range(0, map_bits - n - 1);
        end
        default: n = $urandom_range(0, 2047);
      endcase
      add_request(o, b, n);
    end
  endtask

  // driver: request and config words change at the falling edge
  always @(negedge clk) begin : drive_proc
    logic n_start, n_cfg;
    action_t nxt;
    n_start = start;
    n_cfg = cfg_valid;
    if (!rst) begin
      if (start && requests_taken == requests_sent) n_start = 1'b0;
      if (cfg_valid && cfg_taken == cfg_sent) n_cfg = 1'b0;
      if (!n_start && !n_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          nxt = pending[0];
          case (nxt.kind)
            ACT_REQUEST: begin
              void'(pending.pop_front());
              op <= nxt.req_op;
              start_bit <= nxt.req_bit;
              bit_count <= nxt.req_len;
              n_start = 1'b1;
              requests_sent++;
              if ($urandom_range(0, 99) < nxt.idle_pct) gap_left = $urandom_range(1, 6);
            end
            ACT_CONFIG: begin
              if (outstanding.size() == 0 && !busy) begin
                void'(pending.pop_front());
                cfg_data <= nxt.cfg_val;
                n_cfg = 1'b1;
                cfg_sent++;
              end
            end
            default: begin
              if (outstanding.size() == 0) void'(pending.pop_front());
            end
          endcase
        end
      end
    end
    start <= n_start;
    cfg_valid <= n_cfg;
  end

  // monitor: accepted words and result strobes sampled at the rising edge
  always @(posedge clk) begin : watch_proc
    outcome_t want;
    if (!rst) begin
      if (result_valid) begin
        if (outstanding.size() == 0) begin
          note_failure($sformatf("unexpected result status=%0d position=%0d",
                                 status, position));
        end else begin
          want = outstanding.pop_front();
          if (status !== want.status || position !== want.position)
            note_failure($sformatf("status exp %0d got %0d, position exp %0d got %0d",
                                   want.status, status, want.position, position));
        end
      end
      if (start && !busy) begin
        outstanding.push_back(apply_request(op, start_bit, bit_count));
        requests_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        words_cfg = cfg_data;
        cfg_taken++;
      end
    end
  end

  // stimulus and end of run
  initial begin : stim_proc
    int phase_words [10];
    int ph;
    foreach (map_words[i]) map_words[i] = '0;
    phase_words = '{1, 32, 9, 0, 63, 20, 32, 0, 0, 32};
    phase_words[7] = $urandom_range(1, 32);
    phase_words[8] = $urandom_range(1, 32);

    // directed: full map at 32 words
    add_config(32);
    add_request(OP_SEARCH, 0, 1);
    add_request(OP_SEARCH, 0, 0);
    add_request(OP_SEARCH, 0, 1024);
    add_request(OP_SEARCH, 0, 1023);
    add_request(OP_SEARCH, 1023, 1);
    add_request(OP_SEARCH, 1023, 2);
    add_request(OP_SET_BIT, 0, 0);
    add_request(OP_SET_BIT, 1023, 2047);
    add_request(OP_SEARCH, 0, 1022);
    add_request(OP_SET_RANGE, 30, 5);
    add_request(OP_SEARCH, 2, 29);
    add_request(OP_CLR_RANGE, 31, 2);
    add_request(OP_SET_RANGE, 1000, 24);
    add_request(OP_SET_RANGE, 1000, 23);
    add_request(OP_CLR_RANGE, 1023, 0);
    add_request(OP_SET_RANGE, 1023, 1);
    add_request(OP_CLR_BIT, 0, 0);
    add_request(OP_SEARCH, 0, 2047);
    add_request(OP_NONE, 1023, 2047);
    add_request(OP_SET_ALL, 0, 0);
    add_request(OP_SEARCH, 5, 1);
    add_request(OP_CLR_BIT, 1023, 0);
    add_request(OP_SEARCH, 0, 1);
    add_request(OP_CLR_ALL, 0, 0);
    add_request(OP_SET_RANGE, 0, 1023);
    add_request(OP_SEARCH, 0, 1);

    // random phases across word counts, the last one with no idling
    for (ph = 0; ph < 10; ph++) begin
      idle_pct_now = (ph == 9) ? 0 : ((ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 20 : 50));
      add_config(phase_words[ph]);
      add_random(PHASE_ITEMS / 2, phase_words[ph]);
      add_drain();
      add_random(PHASE_ITEMS - PHASE_ITEMS / 2, phase_words[ph]);
    end

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || start || cfg_valid || outstanding.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (outstanding.size() != 0)
      note_failure($sformatf("%0d results never arrived", outstanding.size()));
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
